@@ rtl/msfk_pkg.sv @@
// msfk_pkg: shared types for the minimum spanning forest core
// holds the sequencer state encoding; no dependencies
package msfk_pkg;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_SCAN,
    ST_CHECK,
    ST_FIND_A,
    ST_FIND_B,
    ST_DONE
  } msfk_state_t;

endpackage

@@ rtl/min_spanning_forest_kruskal_core.sv @@
// min_spanning_forest_kruskal_core: edge store, selection scan and union-find sequencer
// depends on msfk_pkg for the sequencer state type
//
// loading: each start while busy is low takes one edge word, busy stays low until the last edge
// run: each position in weight order costs one full pass over the store, one range check
//   state and, when both vertices are in range, two root searches that follow parent links
//   until a root is reached
// reset (synchronous, rst_n low): empty store, no overflow, vertex count MAX_VERTICES
// results are strobed for one cycle each and cannot be held off by the receiver
module min_spanning_forest_kruskal_core
  import msfk_pkg::*;
#(
  parameter int MAX_VERTICES = 32,
  parameter int EDGE_DEPTH   = 256,
  parameter int WEIGHT_BITS  = 16,
  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
  localparam int CW = $clog2(MAX_VERTICES + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [CW-1:0]                 cfg_wr_data,
  // edge words
  input  logic                          start,
  output logic                          busy,
  input  logic [VW-1:0]                 in_edge_src,
  input  logic [VW-1:0]                 in_edge_dest,
  input  logic signed [WEIGHT_BITS-1:0] in_edge_weight,
  input  logic                          in_last_edge,
  // result words
  output logic                          out_strobe,
  output logic [VW-1:0]                 out_tree_src,
  output logic [VW-1:0]                 out_tree_dest,
  output logic signed [WEIGHT_BITS-1:0] out_tree_weight,
  output logic                          out_has_edge,
  output logic                          out_last_result,
  output logic                          out_edges_lost
);

  localparam int AW = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
  localparam int FW = $clog2(EDGE_DEPTH + 1);
  localparam int EW = 2 * VW + WEIGHT_BITS;
  // sort key: weight with flipped sign bit, then store index for stable ties
  localparam int KW = WEIGHT_BITS + AW;

  msfk_state_t state_r, state_nxt;

  // edge store, packed as {src, dest, weight}
  logic [EW-1:0] mem [EDGE_DEPTH];
  logic [EW-1:0] rd_data_r;
  logic          mem_we, rd_en;

  logic [FW-1:0] fill_r, fill_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] vcount_r;

  // scan pass
  logic [FW-1:0] scan_cnt_r, scan_cnt_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [AW-1:0] rd_idx_r;
  logic          prev_vld_r, prev_vld_nxt;
  logic [KW-1:0] prev_key_r, prev_key_nxt;
  logic          best_vld_r, best_vld_nxt;
  logic [KW-1:0] best_key_r, best_key_nxt;
  logic [EW-1:0] best_edge_r, best_edge_nxt;

  // union-find
  logic [EW-1:0] cur_edge_r, cur_edge_nxt;
  logic [VW-1:0] root_r, root_nxt;
  logic [VW-1:0] ra_r, ra_nxt;
  logic [VW-1:0] parent_r [MAX_VERTICES];
  logic          par_init, par_we;
  logic [CW-1:0] taken_r, taken_nxt;
  logic          pend_vld_r, pend_vld_nxt;
  logic [EW-1:0] pend_edge_r, pend_edge_nxt;

  // result register
  logic                   out_strobe_r, out_strobe_nxt;
  logic [EW-1:0]          out_edge_r, out_edge_nxt;
  logic                   out_has_r, out_has_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_lost_r, out_lost_nxt;

  logic          accept;
  logic [CW-1:0] nv, want;
  logic [VW-1:0] par_rd;
  logic [KW-1:0] cand_key;
  logic          pass_end, after_prev, better;
  logic [VW-1:0] cur_src, cur_dest;

  assign accept = start && (state_r == ST_LOAD);
  assign busy   = (state_r != ST_LOAD);

  // effective vertex count: zero counts as one, large values saturate
  always_comb begin
    if (vcount_r == '0) begin
      nv = CW'(1);
    end else if (vcount_r > CW'(MAX_VERTICES)) begin
      nv = CW'(MAX_VERTICES);
    end else begin
      nv = vcount_r;
    end
  end
  assign want = nv - CW'(1);

  assign par_rd   = parent_r[root_r];
  assign cand_key = {~rd_data_r[WEIGHT_BITS-1], rd_data_r[WEIGHT_BITS-2:0], rd_idx_r};
  assign after_prev = !prev_vld_r || (cand_key > prev_key_r);
  assign better     = !best_vld_r || (cand_key < best_key_r);
  assign pass_end   = (scan_cnt_r == fill_r) && !rd_vld_r;
  assign cur_src    = cur_edge_r[EW-1 -: VW];
  assign cur_dest   = cur_edge_r[EW-VW-1 -: VW];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (accept && in_last_edge) state_nxt = ST_INIT;
      end
      ST_INIT: begin
        state_nxt = (want == '0) ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (pass_end) state_nxt = best_vld_r ? ST_CHECK : ST_DONE;
      end
      ST_CHECK: begin
        if (CW'(cur_src) < nv && CW'(cur_dest) < nv) begin
          state_nxt = ST_FIND_A;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_FIND_A: begin
        if (par_rd == root_r) state_nxt = ST_FIND_B;
      end
      ST_FIND_B: begin
        if (par_rd == root_r) begin
          if (ra_r != root_r && (taken_r + CW'(1)) == want) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_DONE: state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  // datapath and result control
  always_comb begin
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    scan_cnt_nxt  = scan_cnt_r;
    rd_vld_nxt    = 1'b0;
    prev_vld_nxt  = prev_vld_r;
    prev_key_nxt  = prev_key_r;
    best_vld_nxt  = best_vld_r;
    best_key_nxt  = best_key_r;
    best_edge_nxt = best_edge_r;
    cur_edge_nxt  = cur_edge_r;
    root_nxt      = root_r;
    ra_nxt        = ra_r;
    par_init      = 1'b0;
    par_we        = 1'b0;
    taken_nxt     = taken_r;
    pend_vld_nxt  = pend_vld_r;
    pend_edge_nxt = pend_edge_r;
    out_strobe_nxt = 1'b0;
    out_edge_nxt   = out_edge_r;
    out_has_nxt    = out_has_r;
    out_last_nxt   = out_last_r;
    out_lost_nxt   = out_lost_r;

    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (fill_r < FW'(EDGE_DEPTH)) begin
            mem_we   = 1'b1;
            fill_nxt = fill_r + FW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ST_INIT: begin
        par_init     = 1'b1;
        taken_nxt    = '0;
        pend_vld_nxt = 1'b0;
        prev_vld_nxt = 1'b0;
        scan_cnt_nxt = '0;
        best_vld_nxt = 1'b0;
      end
      ST_SCAN: begin
        if (scan_cnt_r < fill_r) begin
          rd_en        = 1'b1;
          rd_vld_nxt   = 1'b1;
          scan_cnt_nxt = scan_cnt_r + FW'(1);
        end
        if (rd_vld_r && after_prev && better) begin
          best_vld_nxt  = 1'b1;
          best_key_nxt  = cand_key;
          best_edge_nxt = rd_data_r;
        end
        if (pass_end && best_vld_r) begin
          prev_vld_nxt = 1'b1;
          prev_key_nxt = best_key_r;
          cur_edge_nxt = best_edge_r;
        end
      end
      ST_CHECK: begin
        root_nxt     = cur_src;
        scan_cnt_nxt = '0;
        best_vld_nxt = 1'b0;
      end
      ST_FIND_A: begin
        if (par_rd == root_r) begin
          ra_nxt   = root_r;
          root_nxt = cur_dest;
        end else begin
          root_nxt = par_rd;
        end
      end
      ST_FIND_B: begin
        if (par_rd == root_r) begin
          if (ra_r != root_r) begin
            par_we        = 1'b1;
            taken_nxt     = taken_r + CW'(1);
            pend_vld_nxt  = 1'b1;
            pend_edge_nxt = cur_edge_r;
            // previous choice is now known not to be the final one
            if (pend_vld_r) begin
              out_strobe_nxt = 1'b1;
              out_edge_nxt   = pend_edge_r;
              out_has_nxt    = 1'b1;
              out_last_nxt   = 1'b0;
              out_lost_nxt   = ovf_r;
            end
          end
        end else begin
          root_nxt = par_rd;
        end
      end
      ST_DONE: begin
        out_strobe_nxt = 1'b1;
        out_edge_nxt   = pend_vld_r ? pend_edge_r : '0;
        out_has_nxt    = pend_vld_r;
        out_last_nxt   = 1'b1;
        out_lost_nxt   = ovf_r;
        fill_nxt       = '0;
        ovf_nxt        = 1'b0;
        pend_vld_nxt   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // edge store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_r[AW-1:0]] <= {in_edge_src, in_edge_dest, in_edge_weight};
    end
    if (rd_en) begin
      rd_data_r <= mem[scan_cnt_r[AW-1:0]];
    end
  end

  // parent table
  always_ff @(posedge clk) begin
    if (!rst_n || par_init) begin
      for (int v = 0; v < MAX_VERTICES; v++) begin
        parent_r[v] <= VW'(v);
      end
    end else if (par_we) begin
      parent_r[ra_r] <= root_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      fill_r       <= '0;
      ovf_r        <= 1'b0;
      vcount_r     <= CW'(MAX_VERTICES);
      rd_vld_r     <= 1'b0;
      prev_vld_r   <= 1'b0;
      best_vld_r   <= 1'b0;
      pend_vld_r   <= 1'b0;
      taken_r      <= '0;
      scan_cnt_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      ovf_r        <= ovf_nxt;
      if (cfg_wr_en) vcount_r <= cfg_wr_data;
      rd_vld_r     <= rd_vld_nxt;
      prev_vld_r   <= prev_vld_nxt;
      best_vld_r   <= best_vld_nxt;
      pend_vld_r   <= pend_vld_nxt;
      taken_r      <= taken_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx_r    <= scan_cnt_r[AW-1:0];
    prev_key_r  <= prev_key_nxt;
    best_key_r  <= best_key_nxt;
    best_edge_r <= best_edge_nxt;
    cur_edge_r  <= cur_edge_nxt;
    root_r      <= root_nxt;
    ra_r        <= ra_nxt;
    pend_edge_r <= pend_edge_nxt;
    out_edge_r  <= out_edge_nxt;
    out_has_r   <= out_has_nxt;
    out_last_r  <= out_last_nxt;
    out_lost_r  <= out_lost_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_tree_src    = out_edge_r[EW-1 -: VW];
  assign out_tree_dest   = out_edge_r[EW-VW-1 -: VW];
  assign out_tree_weight = out_edge_r[WEIGHT_BITS-1:0];
  assign out_has_edge    = out_has_r;
  assign out_last_result = out_last_r;
  assign out_edges_lost  = out_lost_r;

  // never more edges chosen than the forest can hold, checked in every run state after ST_INIT
  a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD && state_r != ST_INIT) |-> taken_r <= want)
    else $error("chosen edge count above vertex count minus one");

  // an empty-forest word is always the final word
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_has_edge |-> out_last_result)
    else $error("empty result not marked final");

  // after the final word the store is empty and loading resumes
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_result |-> !busy && fill_r == '0 && !ovf_r)
    else $error("run end did not clear the store");

  // a word is only strobed while a run is under way or just ended
  a_strobe_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobed outside a run");

endmodule
